// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising clock edge, disabled during reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/nppt_pkg.sv =====
package nppt_pkg;

    localparam int MaxPoints = 64;
    localparam int AddrW     = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);
    localparam int CoordW    = 16;
    localparam int DistW     = 2 * CoordW + 2;

    typedef enum logic [1:0] {
        REQ_ADD   = 2'd0,
        REQ_MOVE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_RESET = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

endpackage

// ===== hw/rtl/nppt_ram.sv =====
module nppt_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/nearest_point_polyline_table_core.sv =====
// nearest_point_polyline_table_core
// Ordered list of up to 64 2-D points held in one RAM (x and y side by side).
// Input word on s_axis: tdata = {coord_y, coord_x}, tuser = req_type.
// Result word on m_axis: tdata = {status, point_total, nearest_index}.
// One request is processed at a time; each request gives one result word.
// Steps per request:
//   reset, or any request on an empty table: answered straight from idle
//   move:   read, add offset, write back, one entry a cycle
//   query:  one distance per cycle from the RAM read port
//   add:    scan as for query, then shift the tail up from pos
// The single RAM read port bounds this work: every entry passes it once
// per scan and once per shifted entry.
// After reset the table is empty; stored points are not cleared, only the
// count. A stalled receiver holds the result in the output register; the
// next request is taken once that word has been sent.
module nearest_point_polyline_table_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [15:0] coord_x, [31:16] coord_y
    input  logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [5:0] nearest_index, [12:6] point_total,
                                        // [14:13] status, [15] zero
);
    import nppt_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MREAD = 8'b0000_0010,
        S_MWR   = 8'b0000_0100,
        S_SCAN  = 8'b0000_1000,
        S_DEC   = 8'b0001_0000,
        S_SHRD  = 8'b0010_0000,
        S_SHWR  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    req_t   req_reg;
    logic [CoordW-1:0] x_reg, y_reg, dx_reg, dy_reg;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   ptr_reg;       // read index
    logic [CntW-1:0]   wptr_reg;      // index of data arriving on rdata
    logic              rv_reg;        // rdata valid this cycle
    logic [AddrW-1:0]  pos_reg;
    logic [AddrW-1:0]  best_idx_reg;
    logic [DistW-1:0]  best_reg;
    logic              have_reg;
    logic [AddrW-1:0]  o_idx_reg;
    logic [1:0]        o_stat_reg;
    logic              m_valid_reg;

    // RAM
    logic                     we;
    logic [AddrW-1:0]         waddr, raddr;
    logic [2*CoordW-1:0]      wdata, rdata;

    nppt_ram #(.Width(2*CoordW), .Depth(MaxPoints)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    logic [CoordW-1:0] rx, ry;
    assign rx = rdata[CoordW-1:0];
    assign ry = rdata[2*CoordW-1:CoordW];

    // distance of the entry on the read port
    logic signed [CoordW:0] ddx, ddy;
    logic [CoordW:0]        adx, ady;
    logic [DistW-1:0]       dist_cur;
    assign ddx  = $signed({rx[CoordW-1], rx}) - $signed({x_reg[CoordW-1], x_reg});
    assign ddy  = $signed({ry[CoordW-1], ry}) - $signed({y_reg[CoordW-1], y_reg});
    assign adx  = ddx[CoordW] ? $unsigned(-ddx) : $unsigned(ddx);
    assign ady  = ddy[CoordW] ? $unsigned(-ddy) : $unsigned(ddy);
    assign dist_cur = DistW'(adx * adx) + DistW'(ady * ady);

    logic accept;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {1'b0, o_stat_reg, count_reg, o_idx_reg};

    // RAM control; entry 0 is read while idle so a scan or move starts on it
    always_comb begin
        we    = 1'b0;
        waddr = wptr_reg[AddrW-1:0];
        wdata = rdata;
        raddr = (state_reg == S_IDLE) ? '0 : ptr_reg[AddrW-1:0];
        if (accept && req_t'(s_axis_tuser) == REQ_RESET) begin
            we    = 1'b1;
            waddr = '0;
            wdata = s_axis_tdata;
        end else if (state_reg == S_MWR && rv_reg) begin
            we    = 1'b1;
            wdata = {ry + dy_reg, rx + dx_reg};
        end else if (state_reg == S_SHWR) begin
            we    = 1'b1;
            waddr = AddrW'(wptr_reg + CntW'(1));
        end else if (state_reg == S_OUT && req_reg == REQ_ADD && o_stat_reg == ST_OK) begin
            we    = 1'b1;
            waddr = pos_reg;
            wdata = {y_reg, x_reg};
        end
    end

    // decision for add, from scan result
    logic [AddrW-1:0] ins_pos;
    logic [AddrW-1:0] dec_pos;
    logic [1:0]       add_stat;
    assign ins_pos = (CntW'(best_idx_reg) == count_reg - CntW'(1))
                     ? count_reg[AddrW-1:0] : best_idx_reg;
    assign dec_pos = (count_reg == CntW'(1)) ? AddrW'(1) : ins_pos;
    always_comb begin
        if (count_reg == CntW'(1)) begin
            add_stat = (count_reg >= CntW'(MaxPoints)) ? ST_FULL : ST_OK;
        end else if (best_reg == '0) begin
            add_stat = ST_DUP;
        end else if (count_reg >= CntW'(MaxPoints)) begin
            add_stat = ST_FULL;
        end else begin
            add_stat = ST_OK;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (req_t'(s_axis_tuser) == REQ_RESET || count_reg == '0) begin
                        state_next = S_IDLE;
                    end else if (req_t'(s_axis_tuser) == REQ_MOVE) begin
                        state_next = S_MREAD;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_MREAD: state_next = S_MWR;
            S_MWR:   if (rv_reg && wptr_reg == count_reg - CntW'(1)) state_next = S_OUT;
            S_SCAN:  if (rv_reg && wptr_reg == count_reg - CntW'(1)) state_next = S_DEC;
            S_DEC: begin
                if (req_reg == REQ_ADD && add_stat == ST_OK && dec_pos != count_reg[AddrW-1:0]
                    && count_reg != CntW'(MaxPoints)) begin
                    state_next = S_SHRD;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_SHRD:  state_next = S_SHWR;
            S_SHWR:  state_next = (wptr_reg[AddrW-1:0] == pos_reg) ? S_OUT : S_SHRD;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            rv_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_axis_tready) m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        req_reg  <= req_t'(s_axis_tuser);
                        x_reg    <= s_axis_tdata[CoordW-1:0];
                        y_reg    <= s_axis_tdata[2*CoordW-1:CoordW];
                        ptr_reg  <= '0;
                        wptr_reg <= '0;
                        rv_reg   <= 1'b0;
                        have_reg <= 1'b0;
                        o_idx_reg  <= '0;
                        o_stat_reg <= ST_OK;
                        if (req_t'(s_axis_tuser) == REQ_RESET) begin
                            count_reg   <= CntW'(1);
                            m_valid_reg <= 1'b1;
                        end else if (count_reg == '0) begin
                            o_stat_reg  <= ST_EMPTY;
                            m_valid_reg <= 1'b1;
                        end else begin
                            rv_reg  <= 1'b1;
                            ptr_reg <= CntW'(1);
                        end
                    end
                end
                S_MREAD: begin
                    // entry 0 on rdata: derive offset
                    dx_reg <= x_reg - rx;
                    dy_reg <= y_reg - ry;
                    ptr_reg  <= '0;
                    wptr_reg <= '0;
                    rv_reg   <= 1'b0;
                end
                S_MWR: begin
                    // read entry ptr, write back entry wptr when its data arrives on rdata
                    if (!rv_reg) begin
                        rv_reg  <= 1'b1;
                        ptr_reg <= ptr_reg + CntW'(1);
                    end else begin
                        wptr_reg <= wptr_reg + CntW'(1);
                        ptr_reg  <= ptr_reg + CntW'(1);
                    end
                end
                S_SCAN: begin
                    if (rv_reg) begin
                        if (!have_reg || dist_cur < best_reg) begin
                            have_reg     <= 1'b1;
                            best_reg     <= dist_cur;
                            best_idx_reg <= wptr_reg[AddrW-1:0];
                        end
                        wptr_reg <= wptr_reg + CntW'(1);
                        ptr_reg  <= ptr_reg + CntW'(1);
                    end
                end
                S_DEC: begin
                    if (req_reg == REQ_QUERY) begin
                        o_idx_reg <= best_idx_reg;
                    end else begin
                        o_idx_reg  <= (count_reg == CntW'(1)) ? '0 : best_idx_reg;
                        o_stat_reg <= add_stat;
                        pos_reg    <= dec_pos;
                        // shift starts at the top entry
                        ptr_reg    <= count_reg - CntW'(1);
                        wptr_reg   <= count_reg - CntW'(1);
                    end
                end
                S_SHRD: ;
                S_SHWR: begin
                    wptr_reg <= wptr_reg - CntW'(1);
                    ptr_reg  <= ptr_reg - CntW'(1);
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    if (req_reg == REQ_ADD && o_stat_reg == ST_OK) begin
                        count_reg <= count_reg + CntW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    `ASSERT_IMPL(a_busy_no_ready, aclk, aresetn, state_reg != S_IDLE, !s_axis_tready, "ready while busy")
    `ASSERT_IMPL(a_count_max, aclk, aresetn, 1'b1, count_reg <= CntW'(MaxPoints), "count overflow")
    `ASSERT_NEXT(a_out_valid, aclk, aresetn, state_reg == S_OUT, m_valid_reg, "result lost")

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import nppt_pkg::*;

    typedef struct packed {
        req_t        req;
        logic [15:0] x;
        logic [15:0] y;
    } request_t;

    typedef struct packed {
        logic [5:0] idx;
        logic [6:0] total;
        status_t    status;
    } answer_t;

    localparam int CycleLimit = 2000000;
    localparam int HoldCycles = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    nearest_point_polyline_table_core dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor copy of the point list
    logic [15:0] pts_x [MaxPoints];
    logic [15:0] pts_y [MaxPoints];
    int          pts_n;

    request_t pending_reqs[$];
    answer_t  expected_answers[$];
    int       mismatches = 0;
    int       answers_seen = 0;
    int       cycle_count = 0;
    int       tx_idle_pct = 22;
    int       rx_idle_pct = 22;
    int       rx_hold = 0;
    int       hold_req = 0;
    int       hold_ack = 0;
    bit       tx_pause = 1'b0;
    int       dup_seen = 0, full_seen = 0, empty_seen = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch #%0d on word %0d: %s got %0d want %0d",
                 mismatches, answers_seen, what, got, want);
        mismatches++;
    endtask

    // nearest stored point; earliest index wins ties
    function automatic int nearest_of(input logic [15:0] x, input logic [15:0] y,
                                      output longint best);
        longint dx, dy, d;
        int     k;
        best = 0;
        nearest_of = 0;
        for (k = 0; k < pts_n; k++) begin
            dx = longint'($signed(pts_x[k])) - longint'($signed(x));
            dy = longint'($signed(pts_y[k])) - longint'($signed(y));
            d  = dx * dx + dy * dy;
            if (k == 0 || d < best) begin
                best = d;
                nearest_of = k;
            end
        end
    endfunction

    function automatic answer_t apply_request(input request_t r);
        answer_t     a;
        longint      best;
        int          k, pos;
        logic [15:0] ox, oy;
        a = '{idx: '0, total: '0, status: ST_OK};
        if (r.req == REQ_RESET) begin
            pts_x[0] = r.x;
            pts_y[0] = r.y;
            pts_n = 1;
        end else if (pts_n == 0) begin
            a.status = ST_EMPTY;
        end else if (r.req == REQ_MOVE) begin
            ox = r.x - pts_x[0];
            oy = r.y - pts_y[0];
            for (k = 0; k < pts_n; k++) begin
                pts_x[k] += ox;
                pts_y[k] += oy;
            end
        end else if (r.req == REQ_QUERY) begin
            a.idx = 6'(nearest_of(r.x, r.y, best));
        end else if (pts_n == 1) begin
            pts_x[1] = r.x;
            pts_y[1] = r.y;
            pts_n = 2;
        end else begin
            a.idx = 6'(nearest_of(r.x, r.y, best));
            if (best == 0) begin
                a.status = ST_DUP;
            end else if (pts_n >= MaxPoints) begin
                a.status = ST_FULL;
            end else begin
                pos = (a.idx == pts_n - 1) ? pts_n : int'(a.idx);
                for (k = pts_n; k > pos; k--) begin
                    pts_x[k] = pts_x[k-1];
                    pts_y[k] = pts_y[k-1];
                end
                pts_x[pos] = r.x;
                pts_y[pos] = r.y;
                pts_n++;
            end
        end
        a.total = 7'(pts_n);
        return a;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() > 0 && !tx_pause &&
                    $urandom_range(99) >= tx_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= pending_reqs[0].req;
                    s_axis_tdata  <= {pending_reqs[0].y, pending_reqs[0].x};
                    expected_answers.insert(expected_answers.size(),
                                            apply_request(pending_reqs[0]));
                    void'(pending_reqs.pop_front());
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver back-pressure, with an optional long hold-off
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (hold_req != hold_ack) begin
            hold_ack      <= hold_req;
            rx_hold       <= HoldCycles;
            m_axis_tready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= aresetn && ($urandom_range(99) >= rx_idle_pct);
        end
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.idx    = m_axis_tdata[5:0];
            got.total  = m_axis_tdata[12:6];
            got.status = status_t'(m_axis_tdata[14:13]);
            answers_seen++;
            if (m_axis_tdata[15] !== 1'b0)
                report_mismatch("pad bit", int'(m_axis_tdata[15]), 0);
            if (expected_answers.size() == 0) begin
                report_mismatch("unexpected word", int'(m_axis_tdata), 0);
            end else begin
                want = expected_answers.pop_front();
                if (got.idx !== want.idx) report_mismatch("nearest_index", got.idx, want.idx);
                if (got.total !== want.total)
                    report_mismatch("point_total", got.total, want.total);
                if (got.status !== want.status)
                    report_mismatch("status", got.status, want.status);
                case (want.status)
                    ST_DUP:   dup_seen++;
                    ST_FULL:  full_seen++;
                    ST_EMPTY: empty_seen++;
                    default: ;
                endcase
            end
        end
    end

    function automatic request_t mk(input req_t q, input logic [15:0] x,
                                    input logic [15:0] y);
        return '{req: q, x: x, y: y};
    endfunction

    task automatic queue_req(input request_t r);
        pending_reqs.insert(pending_reqs.size(), r);
    endtask

    // coordinates: mostly a small cluster so duplicates and ties happen
    function automatic logic [15:0] rnd_coord();
        case ($urandom_range(9))
            0, 1:    return 16'($urandom);
            2:       return $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: return 16'($signed($urandom_range(16)) - 8);
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || expected_answers.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
    endtask

    initial begin
        int k, n, batch;
        pts_n = 0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, every request, duplicates
        queue_req(mk(REQ_ADD, 16'h0001, 16'h0002));
        queue_req(mk(REQ_MOVE, 16'h7fff, 16'h8000));
        queue_req(mk(REQ_QUERY, 16'h0000, 16'h0000));
        queue_req(mk(REQ_RESET, 16'h7fff, 16'h7fff));
        queue_req(mk(REQ_ADD, 16'h8000, 16'h8000));
        queue_req(mk(REQ_ADD, 16'h8000, 16'h8000));
        queue_req(mk(REQ_ADD, 16'h0000, 16'h0000));
        queue_req(mk(REQ_ADD, 16'h7fff, 16'h8000));
        queue_req(mk(REQ_ADD, 16'hffff, 16'hffff));
        queue_req(mk(REQ_QUERY, 16'h7fff, 16'h7fff));
        queue_req(mk(REQ_QUERY, 16'h8000, 16'h7fff));
        queue_req(mk(REQ_MOVE, 16'h8000, 16'h8000));
        queue_req(mk(REQ_QUERY, 16'h0000, 16'h0000));
        queue_req(mk(REQ_MOVE, 16'h0000, 16'h0000));
        queue_req(mk(REQ_RESET, 16'h0000, 16'h0000));
        queue_req(mk(REQ_ADD, 16'h0000, 16'h0000));
        queue_req(mk(REQ_ADD, 16'h0001, 16'h0000));
        queue_req(mk(REQ_QUERY, 16'h0000, 16'h0000));
        queue_req(mk(REQ_ADD, 16'h0000, 16'h0000));
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        hold_req++;
        for (k = 0; k < 20; k++)
            queue_req(mk(REQ_QUERY, rnd_coord(), rnd_coord()));
        wait_drained();

        // sender pauses mid-stream until all answers are back
        for (k = 0; k < 10; k++)
            queue_req(mk(REQ_ADD, rnd_coord(), rnd_coord()));
        while (pending_reqs.size() > 5)
            @(posedge aclk);
        tx_pause = 1'b1;
        while (expected_answers.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        tx_pause = 1'b0;
        wait_drained();

        // random: reset-started point series, some filled to capacity
        n = 0;
        while (n < 2000) begin
            if (n > 600 && n < 900) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = 22;
                rx_idle_pct = 22;
            end
            batch = ($urandom_range(3) == 0) ? 80 : $urandom_range(40, 5);
            if ($urandom_range(9) != 0)
                queue_req(mk(REQ_RESET, rnd_coord(), rnd_coord()));
            for (k = 0; k < batch; k++) begin
                case ($urandom_range(19))
                    0:       queue_req(mk(REQ_MOVE, rnd_coord(), rnd_coord()));
                    1, 2, 3: queue_req(mk(REQ_QUERY, rnd_coord(), rnd_coord()));
                    4:       queue_req(mk(req_t'($urandom_range(3)),
                                          16'($urandom), 16'($urandom)));
                    default: queue_req(mk(REQ_ADD, rnd_coord(), rnd_coord()));
                endcase
            end
            n += batch + 1;
            wait_drained();
        end

        repeat (250) @(posedge aclk);
        $display("covered %0d words: %0d duplicate, %0d full, %0d empty answers",
                 answers_seen, dup_seen, full_seen, empty_seen);
        $display("with long receiver hold-off, sender pause and a no-idle stretch");
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/nppt_pkg.sv
hw/rtl/nppt_ram.sv
hw/rtl/nearest_point_polyline_table_core.sv
verif/tb_top.sv
